### hdl/wms_pkg.sv
package wms_pkg;

    localparam int AngPi      = 25736;
    localparam int Ang2Pi     = 51472;
    localparam int InvGainQ16 = 39797;
    localparam logic signed [41:0] PiFine = 42'sd52707179;

    localparam logic [1:0] RegAngleTol  = 2'd0;
    localparam logic [1:0] RegDefSpeed  = 2'd1;
    localparam logic [1:0] RegSpeedLim  = 2'd2;

    localparam logic OpPose = 1'b0;
    localparam logic OpMove = 1'b1;

    typedef struct packed {
        logic        turn;
        logic [15:0] theta;
        logic [31:0] length;
    } t_task;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] speed_request;
    } t_in;

    typedef struct packed {
        logic               is_reply;
        logic               accepted;
        logic signed [14:0] linear_cmd;
        logic signed [14:0] angular_cmd;
        logic [4:0]         tasks_left;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_SCALE, S_EXEC, S_PUSH, S_OUT
    } t_state;

    function automatic logic [41:0] atan_fine(input logic [4:0] i);
        case (i)
            5'd0:  atan_fine = 42'd13176795;
            5'd1:  atan_fine = 42'd7778716;
            5'd2:  atan_fine = 42'd4110060;
            5'd3:  atan_fine = 42'd2086331;
            5'd4:  atan_fine = 42'd1047214;
            5'd5:  atan_fine = 42'd524117;
            5'd6:  atan_fine = 42'd262123;
            5'd7:  atan_fine = 42'd131069;
            default: atan_fine = 42'd65536 >> (i - 5'd8);
        endcase
    endfunction

    function automatic logic signed [17:0] wrap(input logic signed [17:0] a);
        if (a > 18'sd25736) wrap = a - 18'sd51472;
        else if (a < -18'sd25736) wrap = a + 18'sd51472;
        else wrap = a;
    endfunction

endpackage

### hdl/wms_if.sv
interface wms_if #(parameter int W = 1) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/wms_front.sv
// front: input register that takes a transaction while the back is busy
module wms_front (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wms_if.sink    s_in,
    output logic   o_valid,
    output wms_pkg::t_in o_item,
    input  logic   i_take
);
    import wms_pkg::*;
    logic r_valid;
    t_in  r_item;

    assign s_in.ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (s_in.valid && s_in.ready) r_item <= t_in'(s_in.data);
    end
endmodule

### hdl/wms_back.sv
module wms_back #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wms_pkg::t_in  i_item,
    output logic          o_take,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [13:0]   i_cfg_data,
    wms_if.source         m_out
);
    import wms_pkg::*;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int NS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    t_state r_state, n_state;
    t_in    r_it;
    t_task  r_mem [QUEUE_DEPTH];
    t_task  r_front;
    logic [QW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic signed [31:0] r_cx, r_cy, r_ox, r_oy;
    logic signed [15:0] r_cth;
    logic signed [14:0] r_speed;
    logic r_idle_sent;
    logic [13:0] r_tol;
    logic [12:0] r_defsp;
    logic [13:0] r_lim;
    logic signed [42:0] r_x, r_y;
    logic signed [42:0] r_z;
    logic signed [32:0] r_x0, r_y0;
    logic [4:0] r_i;
    logic [63:0] r_mag;
    logic signed [15:0] r_ang;
    logic [1:0] r_npush, r_pidx;
    t_task r_push [3];
    t_out r_out;
    logic r_ovalid;

    logic pure_turn, exec_go;
    logic [QW-1:0] head_nxt, wr_idx;
    logic [SW-1:0] wr_sum;
    logic signed [16:0] lim17;
    assign pure_turn = r_it.pos_x == 0 && r_it.pos_y == 0 && r_it.heading != 0;

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;
    assign o_take = (r_state == S_IDLE) && i_valid;
    // exec waits while the previous result is still held
    assign exec_go = (r_state == S_EXEC) && (!r_ovalid || m_out.ready);

    // ring pointers wrap at the queue depth
    assign head_nxt = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign wr_sum   = SW'(r_head) + SW'(r_count);
    assign wr_idx   = (wr_sum >= SW'(QUEUE_DEPTH)) ? QW'(wr_sum - SW'(QUEUE_DEPTH))
                                                   : QW'(wr_sum);
    assign lim17    = $signed({3'b000, r_lim});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (o_take) n_state = S_EXEC;
            S_CORDIC: if (r_i == 5'(NS - 1)) n_state = S_SCALE;
            S_SCALE:  n_state = S_EXEC;
            S_EXEC:   if (exec_go) n_state = S_OUT;
            S_PUSH:   if (r_pidx == r_npush - 2'd1) n_state = S_IDLE;
            S_OUT:    n_state = (r_it.opcode == OpMove && r_npush != 2'd0) ? S_PUSH : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    logic signed [42:0] sh_x, sh_y;
    logic signed [17:0] e18, w18;
    logic signed [16:0] err;
    logic [16:0] emag;
    assign sh_x = r_x >>> r_i;
    assign sh_y = r_y >>> r_i;
    assign err  = 17'(r_cth) - 17'($signed(r_front.theta));
    assign emag = err[16] ? 17'(-err) : 17'(err);
    assign w18  = wrap(18'(r_ang) + 18'(r_cth));
    assign e18  = wrap(18'(r_cth) + 18'(r_it.heading));

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            case (i_cfg_idx)
                RegAngleTol: r_tol   <= i_cfg_data;
                RegDefSpeed: r_defsp <= i_cfg_data[12:0];
                RegSpeedLim: r_lim   <= i_cfg_data;
                default: ;
            endcase
        end
        if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
        r_front <= r_mem[r_head];
        case (r_state)
            S_IDLE: begin
                r_it <= i_item;
                if (o_take) begin
                    r_x0 <= 33'(i_item.pos_x);
                    r_y0 <= 33'(i_item.pos_y);
                    if (i_item.opcode == OpPose) begin
                        r_cx <= i_item.pos_x; r_cy <= i_item.pos_y; r_cth <= i_item.heading;
                        r_x0 <= 33'(r_ox) - 33'(i_item.pos_x);
                        r_y0 <= 33'(r_oy) - 33'(i_item.pos_y);
                    end
                end
            end
            S_CORDIC: begin
                if (r_y < 0) begin
                    r_x <= r_x - sh_y; r_y <= r_y + sh_x; r_z <= r_z - 43'(atan_fine(r_i));
                end else begin
                    r_x <= r_x + sh_y; r_y <= r_y - sh_x; r_z <= r_z + 43'(atan_fine(r_i));
                end
                r_i <= r_i + 5'd1;
            end
            S_SCALE: begin
                r_mag <= ((r_x < 0 ? 64'd0 : 64'(r_x)) * 64'(InvGainQ16)
                          + 64'd8388608) >> 24;
                if (r_y0 == 0) r_ang <= r_x0[32] ? 16'(AngPi) : 16'd0;
                else r_ang <= 16'((r_z + 43'sd1024 + (43'sd1 <<< 40)) >>> 11);
            end
            default: ;
        endcase
        if (r_state == S_IDLE && o_take) begin
            r_i <= 5'd0;
        end
        // exec handles both the direct path and the post-cordic path
        if (exec_go) begin
            r_out <= '0;
            if (r_it.opcode == OpMove) begin
                r_out.is_reply <= 1'b1;
                r_out.tasks_left <= 5'(r_count);
                if (pure_turn) begin
                    if (r_count < CW'(QUEUE_DEPTH)) begin
                        r_out.accepted <= 1'b1;
                        r_out.tasks_left <= 5'(r_count + 1'b1);
                        r_push[0] <= '{1'b1, r_it.heading, 32'd0};
                        r_npush <= 2'd1;
                    end else r_npush <= 2'd0;
                end else if (r_count == 0) begin
                    r_out.accepted <= 1'b1;
                    r_out.tasks_left <= 5'(r_count + 2'd3);
                    r_ox <= r_cx; r_oy <= r_cy;
                    r_push[0] <= '{w18 != 0, w18[15:0], 32'd0};
                    r_push[1] <= '{1'b0, 16'd0, (r_mag > 64'hFFFFFFFF) ? 32'hFFFFFFFF
                                                 : r_mag[31:0]};
                    r_push[2] <= '{1'b1, e18[15:0], 32'd0};
                    r_npush <= 2'd3;
                    if (r_it.speed_request == 0) r_speed <= 15'(r_defsp);
                    else if (17'(r_it.speed_request) > lim17) r_speed <= 15'(r_lim);
                    else if (17'(r_it.speed_request) < -lim17) r_speed <= -15'(r_lim);
                    else r_speed <= 15'(r_it.speed_request);
                end else r_npush <= 2'd0;
            end else begin
                r_out.tasks_left <= 5'(r_count);
                if (r_count == 0) begin
                    r_idle_sent <= 1'b1;
                end else begin
                    r_idle_sent <= 1'b0;
                    if (r_front.turn) begin
                        r_out.angular_cmd <= r_speed;
                        if (emag > 17'(r_tol)) begin
                            if (r_cth > 0 && err > 17'sd25736) r_out.angular_cmd <= r_speed;
                            else if (r_cth < 0 && err < -17'sd25736 && err > -17'sd51472)
                                r_out.angular_cmd <= -r_speed;
                            else if (err > 0 && err < 17'sd25736)
                                r_out.angular_cmd <= -r_speed;
                        end else if (emag < 17'(r_tol)) begin
                            r_out.angular_cmd <= '0;
                            r_head <= head_nxt;
                            r_count <= r_count - 1'b1;
                            r_out.tasks_left <= 5'(r_count - 1'b1);
                        end
                    end else if (r_mag < 64'(r_front.length)) begin
                        r_out.linear_cmd <= r_speed;
                    end else begin
                        r_head <= head_nxt;
                        r_count <= r_count - 1'b1;
                        r_out.tasks_left <= 5'(r_count - 1'b1);
                    end
                end
            end
        end
        if (r_state == S_PUSH) begin
            r_mem[wr_idx] <= r_push[r_pidx];
            r_count <= r_count + 1'b1;
            r_pidx <= r_pidx + 2'd1;
        end
        r_state <= n_state;
        if (r_state == S_IDLE && o_take) begin
            // pure turns, rejected requests and pose samples on an empty queue or a turn task skip the cordic
            if (i_item.opcode == OpMove && !(i_item.pos_x == 0 && i_item.pos_y == 0
                && i_item.heading != 0) && r_count == 0)
                r_state <= S_CORDIC;
            else if (i_item.opcode == OpPose && r_count != 0 && !r_mem[r_head].turn)
                r_state <= S_CORDIC;
            else r_state <= S_EXEC;
            if (i_item.opcode == OpMove) begin
                r_x <= 43'($signed(i_item.pos_x)) <<< 8;
                r_y <= 43'($signed(i_item.pos_y)) <<< 8;
                r_z <= '0;
                if (i_item.pos_x[31]) begin
                    r_x <= -(43'($signed(i_item.pos_x)) <<< 8);
                    r_y <= -(43'($signed(i_item.pos_y)) <<< 8);
                    r_z <= i_item.pos_y[31] ? -43'(PiFine) : 43'(PiFine);
                end
            end else begin
                r_x <= 43'(33'(r_ox) - 33'(i_item.pos_x)) <<< 8;
                r_y <= 43'(33'(r_oy) - 33'(i_item.pos_y)) <<< 8;
                r_z <= '0;
                if ($signed(33'(r_ox) - 33'(i_item.pos_x)) < 0) begin
                    r_x <= -(43'(33'(r_ox) - 33'(i_item.pos_x)) <<< 8);
                    r_y <= -(43'(33'(r_oy) - 33'(i_item.pos_y)) <<< 8);
                end
            end
        end
        if (exec_go) begin
            r_pidx <= 2'd0;
            r_ovalid <= !(r_it.opcode == OpPose && r_count == 0 && r_idle_sent);
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_head <= '0; r_count <= '0; r_ovalid <= 1'b0;
            r_cx <= '0; r_cy <= '0; r_cth <= '0; r_ox <= '0; r_oy <= '0;
            r_speed <= '0; r_idle_sent <= 1'b0; r_npush <= '0;
            r_tol <= 14'd164; r_defsp <= 13'd410; r_lim <= 14'd3277;
        end
    end
endmodule

### hdl/waypoint_motion_sequencer.sv
// waypoint motion sequencer
// channels: s_in carries {opcode, pos_x, pos_y, heading, speed_request}, m_out carries
// {is_reply, accepted, linear_cmd, angular_cmd, tasks_left}; valid/ready transactions
// configuration: i_cfg_we with i_cfg_idx selecting tolerance, default speed, speed limit
// a pure turn, a rejected request or a pose sample on a turn task or an empty queue
// skips the cordic and goes from idle straight to exec
// an accepted path request or a pose sample on a line task first passes the cordic and
// scale states for atan2 and length; an accepted request writes its tasks to the queue
// in the push state after its result
// one transaction is processed at a time; the input register holds the next one
// an idle pose sample after the first gives no result
// reset clears queue pointers, poses and speed and restores the register defaults
// while m_out is stalled the result holds; the next transaction is worked up to its
// result and then waits
module waypoint_motion_sequencer #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    wms_if.sink         s_in,
    wms_if.source       m_out
);
    import wms_pkg::*;
    logic fv, take;
    t_in  fitem;

    wms_front u_front (
        .i_clk, .i_rst_n, .s_in, .o_valid(fv), .o_item(fitem), .i_take(take)
    );

    wms_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_valid(fv), .i_item(fitem), .o_take(take),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .m_out
    );
endmodule

### bench/tb_waypoint_motion_sequencer.sv
`timescale 1ns / 1ps

module tb_waypoint_motion_sequencer;
    import wms_pkg::*;

class wms_scoreboard;
    bit              q_turn [16];
    int              q_theta[16];
    longint unsigned q_len  [16];
    int              head;
    int              count;
    int              cur_x, cur_y, cur_th;
    int              org_x, org_y, org_th;
    int              speed;
    bit              idle_sent;
    int              tol;
    int              dspd;
    int              lim;
    t_out            pending[$];
    int              errors;

    function new();
        head = 0; count = 0;
        cur_x = 0; cur_y = 0; cur_th = 0;
        org_x = 0; org_y = 0; org_th = 0;
        speed = 0; idle_sent = 0;
        tol = 164; dspd = 410; lim = 3277;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int v);
        case (idx)
            RegAngleTol: tol = v;
            RegDefSpeed: dspd = v;
            RegSpeedLim: lim = v;
            default: ;
        endcase
    endfunction

    function longint atan_step(int i);
        case (i)
            0: return 13176795;
            1: return 7778716;
            2: return 4110060;
            3: return 2086331;
            4: return 1047214;
            5: return 524117;
            6: return 262123;
            7: return 131069;
            default: return longint'(65536) >> (i - 8);
        endcase
    endfunction

    // vectoring cordic, angle in 1/8192 rad and corrected length
    function void vectorise(longint x0, longint y0, output int a, output longint unsigned m);
        longint x, y, z, nx, ny;
        x = x0 * 256;
        y = y0 * 256;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = (y0 >= 0) ? 52707179 : -52707179;
        end
        for (int i = 0; i < 16; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
            end
            x = nx;
            y = ny;
        end
        if (x < 0) x = 0;
        m = (longint'(x) * 39797 + (longint'(1) << 23)) >> 24;
        if (y0 == 0) a = (x0 >= 0) ? 0 : AngPi;
        else a = int'((z + 1024 + (longint'(1) << 40)) >>> 11) - (1 << 29);
    endfunction

    function int wrap_angle(int a);
        if (a > AngPi) return a - Ang2Pi;
        if (a < -AngPi) return a + Ang2Pi;
        return a;
    endfunction

    function void push_task(bit t, int th, longint unsigned l);
        int idx;
        idx = (head + count) % 16;
        q_turn[idx] = t;
        q_theta[idx] = th;
        q_len[idx] = l;
        count++;
    endfunction

    function void note_input(t_in it);
        int              hd, sp, lin, ang, a, path, err, mag;
        longint unsigned span;
        t_out            e;
        hd = it.heading;
        sp = it.speed_request;
        lin = 0;
        ang = 0;
        e = '0;
        if (it.opcode == OpMove) begin
            e.is_reply = 1'b1;
            if (it.pos_x == 0 && it.pos_y == 0 && hd != 0) begin
                if (count < 16) begin
                    push_task(1'b1, hd, 0);
                    e.accepted = 1'b1;
                end
            end else if (count == 0) begin
                org_x = cur_x; org_y = cur_y; org_th = cur_th;
                vectorise(it.pos_x, it.pos_y, a, span);
                path = wrap_angle(a + org_th);
                push_task(path != 0, path, 0);
                push_task(1'b0, 0, (span > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : span);
                push_task(1'b1, wrap_angle(org_th + hd), 0);
                if (sp == 0) speed = dspd;
                else speed = (sp > lim) ? lim : ((sp < -lim) ? -lim : sp);
                e.accepted = 1'b1;
            end
            e.tasks_left = count[4:0];
            pending = {pending, e};
            return;
        end
        cur_x = it.pos_x; cur_y = it.pos_y; cur_th = hd;
        if (count == 0) begin
            if (idle_sent) return;
            idle_sent = 1;
        end else begin
            idle_sent = 0;
            if (q_turn[head]) begin
                err = hd - q_theta[head];
                mag = (err < 0) ? -err : err;
                ang = speed;
                if (mag > tol) begin
                    if (hd > 0 && err > AngPi && err < Ang2Pi) ang = speed;
                    else if (hd < 0 && err > -Ang2Pi && err < -AngPi) ang = -speed;
                    else if (err > 0 && err < AngPi) ang = -speed;
                    else ang = speed;
                end else if (mag < tol) begin
                    ang = 0;
                    head = (head + 1) % 16;
                    count--;
                end
            end else begin
                vectorise(longint'(org_x) - cur_x, longint'(org_y) - cur_y, a, span);
                if (span < q_len[head]) lin = speed;
                else begin
                    head = (head + 1) % 16;
                    count--;
                end
            end
        end
        e.linear_cmd = lin[14:0];
        e.angular_cmd = ang[14:0];
        e.tasks_left = count[4:0];
        pending = {pending, e};
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(t_out r);
        t_out e;
        if (pending.size() == 0) begin
            report("unexpected result transaction", 1, 0);
            return;
        end
        e = pending.pop_front();
        if (r.is_reply !== e.is_reply) report("is_reply", r.is_reply, e.is_reply);
        if (r.accepted !== e.accepted) report("accepted", r.accepted, e.accepted);
        if (r.linear_cmd !== e.linear_cmd) report("linear_cmd", r.linear_cmd, e.linear_cmd);
        if (r.angular_cmd !== e.angular_cmd)
            report("angular_cmd", r.angular_cmd, e.angular_cmd);
        if (r.tasks_left !== e.tasks_left) report("tasks_left", r.tasks_left, e.tasks_left);
    endtask
endclass

    localparam int SettleCycles = 40;
    localparam int StallLimit   = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [13:0] i_cfg_data;

    wms_if #(.W($bits(t_in)))  in_ch  (i_clk);
    wms_if #(.W($bits(t_out))) out_ch (i_clk);

    waypoint_motion_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    wms_scoreboard sb;
    int            send_idle;
    int            recv_stall;
    int            quiet_cycles;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom % 100) >= recv_stall;
        if (out_ch.valid && out_ch.ready) sb.check_result(t_out'(out_ch.data));
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task send(t_in it);
        int gap;
        gap = 0;
        while (($urandom % 100) < send_idle) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
    endtask

    task settle();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, int v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[13:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task send_fields(logic op, int x, int y, int h, int s);
        t_in it;
        it.opcode = op;
        it.pos_x = x;
        it.pos_y = y;
        it.heading = h[15:0];
        it.speed_request = s[15:0];
        send(it);
    endtask

    function int rand_heading();
        return int'($urandom_range(0, 2 * AngPi)) - AngPi;
    endfunction

    function int clip_heading(int h);
        if (h > AngPi) return AngPi;
        if (h < -AngPi) return -AngPi;
        return h;
    endfunction

    function int rand_offset();
        case ($urandom % 4)
            0: return int'($urandom);
            1: return int'($urandom_range(0, 2000)) - 1000;
            default: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    task directed();
        send_fields(OpPose, 0, 0, 0, 0);            // first idle sample gives a stop
        send_fields(OpPose, 5, -5, 100, 0);         // second idle sample is silent
        send_fields(OpMove, 0, 0, 0, 0);            // turn to the current heading, a zero line, then a turn to it again
        send_fields(OpMove, 0, 0, AngPi, 1);        // pure turn while path is queued
        send_fields(OpMove, 1000, 1000, 0, 0);      // path rejected, queue not empty
        send_fields(OpPose, 0, 0, 0, 0);
        send_fields(OpPose, 0, 0, 0, 0);
        send_fields(OpPose, 0, 0, 0, 0);
        send_fields(OpPose, 0, 0, -AngPi, 0);
        send_fields(OpPose, 0, 0, AngPi, 0);
        send_fields(OpPose, 0, 0, 3000, 0);
        send_fields(OpMove, int'(32'h8000_0000), int'(32'h7FFF_FFFF), -AngPi, -32768);
        send_fields(OpPose, 0, 0, 25000, 0);
        send_fields(OpPose, -20000, 0, -25000, 0);
        for (int i = 0; i < 14; i++) send_fields(OpMove, 0, 0, -AngPi + i * 3000, 0);
        send_fields(OpMove, -100, 0, 200, 32767);   // rejected, queue full
    endtask

    task random_items(int n);
        int r, h, idx;
        for (int k = 0; k < n; k++) begin
            r = $urandom % 100;
            idx = sb.head;
            if (r < 25 && sb.count == 0) begin
                send_fields(OpMove, rand_offset(), rand_offset(), rand_heading(),
                            ($urandom % 3 == 0) ? 0 : int'($urandom));
            end else if (r < 32) begin
                h = rand_heading();
                send_fields(OpMove, 0, 0, (h == 0) ? 1 : h, int'($urandom));
            end else if (r < 38) begin
                send_fields(1'($urandom % 2), int'($urandom), int'($urandom), rand_heading(),
                            int'($urandom));
            end else if (sb.count > 0 && sb.q_turn[idx] && ($urandom % 10) < 7) begin
                h = sb.q_theta[idx] + int'($urandom_range(0, 2 * sb.tol + 40)) - sb.tol - 20;
                send_fields(OpPose, sb.cur_x, sb.cur_y, clip_heading(h), 0);
            end else if (sb.count > 0 && !sb.q_turn[idx] && ($urandom % 10) < 7) begin
                if ($urandom % 2)
                    send_fields(OpPose, sb.org_x + int'(sb.q_len[idx]) + rand_offset() % 64,
                                sb.org_y, rand_heading(), 0);
                else
                    send_fields(OpPose, sb.org_x + rand_offset() % 4096,
                                sb.org_y + rand_offset() % 4096, rand_heading(), 0);
            end else begin
                send_fields(OpPose, rand_offset(), rand_offset(), rand_heading(),
                            int'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = RegAngleTol;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        random_items(130);
        settle();

        // extremes high, sender mostly idle
        write_reg(RegAngleTol, 8192);
        write_reg(RegDefSpeed, 4096);
        write_reg(RegSpeedLim, 8192);
        send_idle = 66;
        random_items(130);
        settle();

        // zero tolerance never completes a turn
        write_reg(RegAngleTol, 0);
        write_reg(RegDefSpeed, 0);
        write_reg(RegSpeedLim, 0);
        send_idle = 0;
        recv_stall = 66;
        random_items(130);
        settle();

        write_reg(RegAngleTol, 300);
        write_reg(RegDefSpeed, 1);
        write_reg(RegSpeedLim, 1);
        send_idle = 11;
        recv_stall = 11;
        random_items(130);
        settle();

        write_reg(RegAngleTol, $urandom_range(1, 8192));
        write_reg(RegDefSpeed, $urandom_range(0, 4096));
        write_reg(RegSpeedLim, $urandom_range(0, 8192));
        send_idle = 0;
        recv_stall = 0;
        random_items(130);
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
